@@ rtl/sfd_pkg.sv @@
// Shared types and constants for the stereo feedback delay core.
// Holds the register map, reset values and the configuration struct; no dependencies.
package sfd_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIX      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK = 2'd2;

   localparam logic [CSR_DATA_BITS-1:0] DELAY_RESET    = 16'd13440;
   localparam logic [CSR_DATA_BITS-1:0] MIX_RESET      = 16'd0;
   localparam logic [CSR_DATA_BITS-1:0] FEEDBACK_RESET = 16'd11796;

   // one half in Q0.16
   localparam int Q16_HALF = 32768;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] delay_length;
      logic [CSR_DATA_BITS-1:0] mix_level;
      logic [CSR_DATA_BITS-1:0] feedback_gain;
   } cfg_type;

endpackage

@@ rtl/stereo_feedback_delay_core.sv @@
// Stereo feedback delay (echo) core: top level with pointer logic, hazard forwarding
// and output register. Depends on sfd_pkg, sfd_csr, sfd_mix and sfd_ram.
//
// One stereo request per clock is accepted while req_stall is low. Each result passes
// the store read and multiply, then rounding, saturation and write back, before it is
// loaded into the output register. The rate is set by the echo store, one
// read and one write per cycle. The write of the request one stage ahead, and the write
// that completes in the cycle of the read, are forwarded to a later read of the same
// entry. The store needs no clearing pass: entries are filled in pointer order, so an
// entry not yet reached by the write pointer since reset reads as zero. A mix level of
// zero passes the frame through without touching the store or the pointer.
// Configuration writes are taken at any time but must only be made while no request
// is in flight.
module stereo_feedback_delay_core #(
   parameter int STORE_DEPTH = 65536,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [SAMPLE_BITS-1:0]    req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]    req_right_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]    rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]    rsp_right_out,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sfd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sfd_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int SB = SAMPLE_BITS;
   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;

   sfd_pkg::cfg_type cfg;

   logic          active;
   logic          accept;
   logic          out_ready;
   logic          s2_free;
   logic          s1_free;
   logic          s1_to_s2;
   logic          s2_to_out;
   logic          mem_wr;

   logic [CW-1:0] d_raw;
   logic [CW-1:0] d_clamp;
   logic [CW-1:0] rd_wide;
   logic [AW-1:0] rd_addr;
   logic          rd_known;

   logic [AW-1:0] wp_ff, wp_in;
   logic          wrapped_ff, wrapped_in;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_active_ff;
   logic          s1_known_ff;
   logic [AW-1:0] s1_rd_ff;
   logic [AW-1:0] s1_wp_ff;
   logic signed [SB-1:0] s1_left_ff;
   logic signed [SB-1:0] s1_right_ff;

   logic          s2_valid_ff, s2_valid_in;
   logic          s2_active_ff;
   logic [AW-1:0] s2_wp_ff;

   logic          lw_valid_ff, lw_valid_in;
   logic [AW-1:0] lw_addr_ff;
   logic [2*SB-1:0] lw_data_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0] rsp_left_ff;
   logic signed [SB-1:0] rsp_right_ff;

   logic [2*SB-1:0] ram_rd_data;
   logic [2*SB-1:0] wr_data;
   logic [2*SB-1:0] y_pair;
   logic signed [SB-1:0] y_left;
   logic signed [SB-1:0] y_right;
   logic signed [SB-1:0] out_left;
   logic signed [SB-1:0] out_right;
   logic signed [SB-1:0] wr_left;
   logic signed [SB-1:0] wr_right;

   sfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // pipeline flow
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_ready;
   assign s2_to_out = s2_valid_ff && out_ready;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s1_to_s2  = s1_valid_ff && s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;
   assign active    = cfg.mix_level != '0;
   assign mem_wr    = s2_to_out && s2_active_ff;

   // read address: clamped delay behind the write pointer
   always_comb begin
      d_raw = CW'(cfg.delay_length);
      if (d_raw == '0) begin
         d_clamp = CW'(1);
      end else if (d_raw > CW'(STORE_DEPTH - 1)) begin
         d_clamp = CW'(STORE_DEPTH - 1);
      end else begin
         d_clamp = d_raw;
      end
      if (CW'(wp_ff) >= d_clamp) begin
         rd_wide = CW'(wp_ff) - d_clamp;
      end else begin
         rd_wide = CW'(wp_ff) + CW'(STORE_DEPTH) - d_clamp;
      end
      rd_addr  = rd_wide[AW-1:0];
      rd_known = wrapped_ff || (rd_addr < wp_ff);
   end

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (accept && active) begin
         if (wp_ff == AW'(STORE_DEPTH - 1)) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + AW'(1);
         end
      end
      s1_valid_in  = accept ? 1'b1 : (s1_to_s2 ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_to_s2 ? 1'b1 : (s2_to_out ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_to_out ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);
      lw_valid_in  = lw_valid_ff || mem_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lw_valid_ff  <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         lw_valid_ff  <= lw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_active_ff <= active;
         s1_known_ff  <= active && rd_known;
         s1_rd_ff     <= rd_addr;
         s1_wp_ff     <= wp_ff;
         s1_left_ff   <= req_left_in;
         s1_right_ff  <= req_right_in;
      end
      if (s1_to_s2) begin
         s2_active_ff <= s1_active_ff;
         s2_wp_ff     <= s1_wp_ff;
      end
      if (mem_wr) begin
         lw_addr_ff <= s2_wp_ff;
         lw_data_ff <= wr_data;
      end
      if (s2_to_out) begin
         rsp_left_ff  <= out_left;
         rsp_right_ff <= out_right;
      end
   end

   sfd_ram #(
      .WIDTH (2 * SB),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (s2_wp_ff),
      .wr_data (wr_data),
      .rd_en   (accept && active),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign wr_data = {wr_left, wr_right};

   // newest write wins: stage two, then the last completed write, then the store
   always_comb begin
      if (!s1_known_ff) begin
         y_pair = '0;
      end else if (s2_valid_ff && s2_active_ff && (s2_wp_ff == s1_rd_ff)) begin
         y_pair = wr_data;
      end else if (lw_valid_ff && (lw_addr_ff == s1_rd_ff)) begin
         y_pair = lw_data_ff;
      end else begin
         y_pair = ram_rd_data;
      end
   end

   assign y_left  = y_pair[2*SB-1:SB];
   assign y_right = y_pair[SB-1:0];

   sfd_mix #(
      .SAMPLE_BITS (SB)
   ) u_mix_left (
      .clock         (clock),
      .load          (s1_to_s2),
      .x_in          (s1_left_ff),
      .y_in          (y_left),
      .mix_level     (cfg.mix_level),
      .feedback_gain (cfg.feedback_gain),
      .out_sample    (out_left),
      .wr_sample     (wr_left)
   );

   sfd_mix #(
      .SAMPLE_BITS (SB)
   ) u_mix_right (
      .clock         (clock),
      .load          (s1_to_s2),
      .x_in          (s1_right_ff),
      .y_in          (y_right),
      .mix_level     (cfg.mix_level),
      .feedback_gain (cfg.feedback_gain),
      .out_sample    (out_right),
      .wr_sample     (wr_right)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

endmodule

@@ rtl/sfd_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module sfd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sfd_csr.sv @@
// Configuration registers of the delay core: delay, mix and feedback.
// Depends on sfd_pkg for the register map and reset values.
module sfd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sfd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sfd_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output sfd_pkg::cfg_type                 cfg
);

   sfd_pkg::cfg_type cfg_ff;
   sfd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sfd_pkg::CSR_DELAY:    cfg_in.delay_length  = csr_data;
            sfd_pkg::CSR_MIX:      cfg_in.mix_level     = csr_data;
            sfd_pkg::CSR_FEEDBACK: cfg_in.feedback_gain = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_length  <= sfd_pkg::DELAY_RESET;
         cfg_ff.mix_level     <= sfd_pkg::MIX_RESET;
         cfg_ff.feedback_gain <= sfd_pkg::FEEDBACK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

@@ rtl/sfd_mix.sv @@
// Per-channel arithmetic: registered blend and feedback products, then rounding and
// saturation of the output sample and the sample written back. Depends on sfd_pkg.
module sfd_mix #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [SAMPLE_BITS-1:0] x_in,
   input  logic signed [SAMPLE_BITS-1:0] y_in,
   input  logic [sfd_pkg::CSR_DATA_BITS-1:0] mix_level,
   input  logic [sfd_pkg::CSR_DATA_BITS-1:0] feedback_gain,
   output logic signed [SAMPLE_BITS-1:0] out_sample,
   output logic signed [SAMPLE_BITS-1:0] wr_sample
);

   localparam int SB  = SAMPLE_BITS;
   localparam int PMW = SB + 18;
   localparam int PFW = SB + 17;
   localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

   logic signed [SB:0]     diff;
   logic signed [16:0]     mix_s;
   logic signed [16:0]     fb_s;
   logic signed [PMW-1:0]  pm_in;
   logic signed [PFW-1:0]  pf_in;
   logic signed [PMW-1:0]  pm_ff;
   logic signed [PFW-1:0]  pf_ff;
   logic signed [SB-1:0]   x_ff;
   logic signed [PMW:0]    pm_r;
   logic signed [PFW:0]    pf_r;
   logic signed [SB+2:0]   mix_q;
   logic signed [SB+1:0]   fb_q;
   logic signed [SB+3:0]   out_wide;
   logic signed [SB+2:0]   wr_wide;
   logic [4:0]             out_hi;
   logic [3:0]             wr_hi;

   // blend = x + (y - x) * m / 65536
   assign diff  = {y_in[SB-1], y_in} - {x_in[SB-1], x_in};
   assign mix_s = {1'b0, mix_level};
   assign fb_s  = {1'b0, feedback_gain};
   assign pm_in = diff * mix_s;
   assign pf_in = y_in * fb_s;

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff  <= x_in;
         pm_ff <= pm_in;
         pf_ff <= pf_in;
      end
   end

   assign pm_r  = {pm_ff[PMW-1], pm_ff} + (PMW+1)'(sfd_pkg::Q16_HALF);
   assign pf_r  = {pf_ff[PFW-1], pf_ff} + (PFW+1)'(sfd_pkg::Q16_HALF);
   assign mix_q = pm_r[PMW:16];
   assign fb_q  = pf_r[PFW:16];

   assign out_wide = {{4{x_ff[SB-1]}}, x_ff} + {mix_q[SB+2], mix_q};
   assign wr_wide  = {{3{x_ff[SB-1]}}, x_ff} + {{1{fb_q[SB+1]}}, fb_q};
   assign out_hi   = out_wide[SB+3:SB-1];
   assign wr_hi    = wr_wide[SB+2:SB-1];

   always_comb begin
      if ((&out_hi) || !(|out_hi)) begin
         out_sample = out_wide[SB-1:0];
      end else begin
         out_sample = out_hi[4] ? SMIN : SMAX;
      end
      if ((&wr_hi) || !(|wr_hi)) begin
         wr_sample = wr_wide[SB-1:0];
      end else begin
         wr_sample = wr_hi[3] ? SMIN : SMAX;
      end
   end

endmodule

@@ dv/stereo_feedback_delay_core_test.sv @@
// Self-checking testbench for stereo_feedback_delay_core: queued stereo requests,
// random idling on both channels and an in-order echo predictor checked per result.
// Depends on sfd_pkg and the stereo_feedback_delay_core RTL.
module stereo_feedback_delay_core_test;

   localparam int STORE_DEPTH    = 65536;
   localparam int SAMPLE_BITS    = 24;
   localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
   localparam int SETTLE_CYCLES  = 8;
   localparam int STALL_STRETCH  = 300;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 108;
   localparam int MAX_REPORTS    = 10;
   localparam logic [sfd_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam logic [sfd_pkg::CSR_DATA_BITS-1:0]  FEEDBACK_NOMINAL_MAX = 16'd53740;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
   } frame_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic signed [SAMPLE_BITS-1:0]   req_left_in = '0;
   logic signed [SAMPLE_BITS-1:0]   req_right_in = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0]   rsp_left_out;
   logic signed [SAMPLE_BITS-1:0]   rsp_right_out;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [sfd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [sfd_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;

   logic signed [SAMPLE_BITS-1:0] store_left [STORE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] store_right [STORE_DEPTH];
   int unsigned      wr_ptr;
   sfd_pkg::cfg_type shadow_cfg;

   frame_type req_pending[$];
   frame_type echo_expected[$];

   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   logic        csr_taken = 1'b0;
   bit          req_idle = 1'b0;
   bit          rsp_idle = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_wait = 0;
   int unsigned freeze_count = 0;
   int unsigned freeze_seen = 0;
   int unsigned idle_cycles = 0;
   int unsigned mismatches = 0;

   stereo_feedback_delay_core #(
      .STORE_DEPTH(STORE_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_left_in(req_left_in),
      .req_right_in(req_right_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_out(rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint round_q16(longint v);
      return (v + sfd_pkg::Q16_HALF) >>> 16;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] wet_blend(
      logic signed [SAMPLE_BITS-1:0] dry, logic signed [SAMPLE_BITS-1:0] tap);
      longint wet;
      longint acc;
      wet = longint'(shadow_cfg.mix_level);
      acc = longint'(dry) * (65536 - wet) + longint'(tap) * wet;
      return clip_sample(round_q16(acc));
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] echo_feedback(
      logic signed [SAMPLE_BITS-1:0] dry, logic signed [SAMPLE_BITS-1:0] tap);
      return clip_sample(longint'(dry)
                         + round_q16(longint'(tap) * longint'(shadow_cfg.feedback_gain)));
   endfunction

   function automatic void reset_echo_model();
      store_left = '{default: '0};
      store_right = '{default: '0};
      wr_ptr = 0;
      shadow_cfg = '{sfd_pkg::DELAY_RESET, sfd_pkg::MIX_RESET, sfd_pkg::FEEDBACK_RESET};
   endfunction

   function automatic void apply_csr(logic [sfd_pkg::CSR_INDEX_BITS-1:0] idx,
                                     logic [sfd_pkg::CSR_DATA_BITS-1:0] value);
      case (idx)
         sfd_pkg::CSR_DELAY:    shadow_cfg.delay_length = value;
         sfd_pkg::CSR_MIX:      shadow_cfg.mix_level = value;
         sfd_pkg::CSR_FEEDBACK: shadow_cfg.feedback_gain = value;
         default: ;
      endcase
   endfunction

   function automatic frame_type predict_echo(frame_type din);
      frame_type dout;
      int unsigned lag;
      int unsigned rd;
      logic signed [SAMPLE_BITS-1:0] tap_l;
      logic signed [SAMPLE_BITS-1:0] tap_r;
      // zero mix: bypass, store and pointer untouched
      if (shadow_cfg.mix_level == 0) return din;
      lag = shadow_cfg.delay_length;
      if (lag < 1) lag = 1;
      if (lag > STORE_DEPTH - 1) lag = STORE_DEPTH - 1;
      rd = (wr_ptr + STORE_DEPTH - lag) % STORE_DEPTH;
      tap_l = store_left[ADDR_BITS'(rd)];
      tap_r = store_right[ADDR_BITS'(rd)];
      dout.left = wet_blend(din.left, tap_l);
      dout.right = wet_blend(din.right, tap_r);
      store_left[ADDR_BITS'(wr_ptr)] = echo_feedback(din.left, tap_l);
      store_right[ADDR_BITS'(wr_ptr)] = echo_feedback(din.right, tap_r);
      wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
      return dout;
   endfunction

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
   endfunction

   function automatic void push_frame(logic signed [SAMPLE_BITS-1:0] l,
                                      logic signed [SAMPLE_BITS-1:0] r);
      req_pending.insert(req_pending.size(), frame_type'{l, r});
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return SAMPLE_BITS'(int'($urandom_range(0, 31)) - 16);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // request/result scoreboard
   always @(posedge clock) begin
      frame_type want;
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      csr_taken <= !reset && csr_valid && csr_ready;
      if (reset) begin
         reset_echo_model();
      end else begin
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_data);
         if (req_valid && !req_stall)
            echo_expected.insert(echo_expected.size(),
                                 predict_echo(frame_type'{req_left_in, req_right_in}));
         if (rsp_valid && !rsp_stall) begin
            if (echo_expected.size() == 0) begin
               note_mismatch($sformatf("unexpected result left %0d right %0d",
                                       rsp_left_out, rsp_right_out));
            end else begin
               want = echo_expected.pop_front();
               if (rsp_left_out !== want.left)
                  note_mismatch($sformatf("left_out expected %0d, got %0d",
                                          want.left, rsp_left_out));
               if (rsp_right_out !== want.right)
                  note_mismatch($sformatf("right_out expected %0d, got %0d",
                                          want.right, rsp_right_out));
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      frame_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
      end else if (req_gap != 0) begin
         req_valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (req_pending.size() != 0) begin
         item = req_pending.pop_front();
         req_valid <= 1'b1;
         req_left_in <= item.left;
         req_right_in <= item.right;
         req_gap <= req_idle ? $urandom_range(0, 15) : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result receiver
   always @(negedge clock) begin
      int unsigned pause;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait <= 0;
      end else if (freeze_seen != freeze_count) begin
         freeze_seen <= freeze_count;
         rsp_stall <= 1'b1;
         rsp_wait <= STALL_STRETCH;
      end else if (rsp_wait != 0) begin
         rsp_stall <= 1'b1;
         rsp_wait <= rsp_wait - 1;
      end else if (rsp_taken) begin
         pause = rsp_idle ? $urandom_range(0, 15) : 0;
         rsp_stall <= (pause != 0);
         rsp_wait <= (pause == 0) ? 0 : pause - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_csr(logic [sfd_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [sfd_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (req_pending.size() != 0 || req_valid || echo_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [sfd_pkg::CSR_DATA_BITS-1:0] lag;
      logic [sfd_pkg::CSR_DATA_BITS-1:0] wet;
      logic [sfd_pkg::CSR_DATA_BITS-1:0] fb;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bypass with reset settings
      push_frame(SAMPLE_MAX, SAMPLE_MIN);
      push_frame(SAMPLE_MIN, SAMPLE_MAX);
      push_frame(0, -1);
      push_frame(1, 0);
      drain();

      // zero delay, full wet, feedback above nominal
      write_csr(sfd_pkg::CSR_DELAY, 16'd0);
      write_csr(sfd_pkg::CSR_MIX, 16'hFFFF);
      write_csr(sfd_pkg::CSR_FEEDBACK, 16'hFFFF);
      push_frame(SAMPLE_MAX, SAMPLE_MAX);
      push_frame(SAMPLE_MAX, SAMPLE_MAX);
      push_frame(SAMPLE_MIN, SAMPLE_MIN);
      push_frame(SAMPLE_MIN, SAMPLE_MIN);
      push_frame(SAMPLE_MAX, SAMPLE_MIN);
      push_frame(SAMPLE_MIN, SAMPLE_MAX);
      push_frame(0, 0);
      push_frame(-1, 1);
      drain();

      write_csr(CSR_SPARE, 16'h5A5A);
      write_csr(sfd_pkg::CSR_DELAY, 16'd1);
      write_csr(sfd_pkg::CSR_MIX, 16'd1);
      write_csr(sfd_pkg::CSR_FEEDBACK, 16'd0);
      push_frame(SAMPLE_MAX, SAMPLE_MIN);
      push_frame(SAMPLE_MIN, SAMPLE_MAX);
      push_frame(1, -1);
      push_frame(-1, 1);
      push_frame(0, 0);
      drain();

      write_csr(sfd_pkg::CSR_DELAY, 16'hFFFF);
      write_csr(sfd_pkg::CSR_MIX, 16'h8000);
      write_csr(sfd_pkg::CSR_FEEDBACK, FEEDBACK_NOMINAL_MAX);
      push_frame(SAMPLE_MAX, SAMPLE_MAX);
      push_frame(SAMPLE_MIN, SAMPLE_MIN);
      push_frame(1, -1);
      push_frame(-1, 1);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         req_idle = ($urandom_range(0, 2) != 0);
         rsp_idle = ($urandom_range(0, 2) != 0);
         case ($urandom_range(0, 5))
            0: lag = 16'd0;
            1: lag = 16'hFFFF;
            2: lag = 16'($urandom_range(1, 4));
            default: lag = 16'($urandom_range(1, 60));
         endcase
         case ($urandom_range(0, 6))
            0: wet = 16'd0;
            1: wet = 16'hFFFF;
            2: wet = 16'd1;
            default: wet = 16'($urandom_range(1, 65535));
         endcase
         case ($urandom_range(0, 5))
            0: fb = 16'd0;
            1: fb = FEEDBACK_NOMINAL_MAX;
            2: fb = 16'hFFFF;
            default: fb = 16'($urandom_range(0, FEEDBACK_NOMINAL_MAX));
         endcase
         if (phase == 3 && wet == 0) wet = 16'd40000;
         write_csr(sfd_pkg::CSR_DELAY, lag);
         write_csr(sfd_pkg::CSR_MIX, wet);
         write_csr(sfd_pkg::CSR_FEEDBACK, fb);
         if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE, 16'($urandom));
         if (phase == 3) begin
            req_idle = 1'b0;
            freeze_count++;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) push_frame(random_sample(), random_sample());
         drain();
      end

      if (mismatches == 0 && echo_expected.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
